// ----- hdl/prc_pkg.sv -----
package prc_pkg;

   // Sample format and coefficient scaling
   localparam int DATA_W     = 32;
   localparam int FRAC_BITS  = 16;
   localparam int COEF_SHIFT = 28;
   localparam int KP_SHIFT   = 24;

   // Reset value of the resonant history
   localparam logic signed [DATA_W-1:0] INIT_RESONANT = 32'sd0;

   // Derived widths: four-product sum, its truncation, slew difference,
   // proportional term and drive sum
   localparam int SUM_W   = 2 * DATA_W + 2;
   localparam int UR_W    = SUM_W - COEF_SHIFT;
   localparam int DIFF_W  = UR_W + 1;
   localparam int UP_W    = 2 * DATA_W - KP_SHIFT;
   localparam int DRIVE_W = UP_W + 1;

   localparam int CSR_ADDR_W = 3;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_COEF_A1   = 3'd0,
      CSR_COEF_A2   = 3'd1,
      CSR_COEF_BR   = 3'd2,
      CSR_PROP_GAIN = 3'd3,
      CSR_RES_MAX   = 3'd4,
      CSR_RES_MIN   = 3'd5,
      CSR_OUT_MAX   = 3'd6,
      CSR_OUT_MIN   = 3'd7
   } csr_index_type;

   // Settings of the resonant branch
   typedef struct packed {
      logic signed [DATA_W-1:0] coef_a1;
      logic signed [DATA_W-1:0] coef_a2;
      logic signed [DATA_W-1:0] coef_br;
      logic signed [DATA_W-1:0] res_max;
      logic signed [DATA_W-1:0] res_min;
   } res_cfg_type;

endpackage

// ----- hdl/prc_resonant.sv -----
module prc_resonant (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 step_en,
   input  logic signed [prc_pkg::DATA_W-1:0]    error,
   input  prc_pkg::res_cfg_type                 cfg,
   output logic signed [prc_pkg::DATA_W-1:0]    resonant
);

   localparam int DW = prc_pkg::DATA_W;
   localparam logic signed [prc_pkg::DIFF_W-1:0] ONE_W =
      prc_pkg::DIFF_W'(1) <<< prc_pkg::FRAC_BITS;

   logic signed [DW-1:0] error_d1_ff, error_d2_ff;
   logic signed [DW-1:0] resonant_d1_ff, resonant_d2_ff;

   logic signed [2*DW-1:0]              prod_be, prod_bd, prod_a1, prod_a2;
   logic signed [prc_pkg::SUM_W-1:0]    sum;
   logic signed [prc_pkg::UR_W-1:0]     ur_raw;
   logic signed [prc_pkg::DIFF_W-1:0]   ur_ext, hist_ext, diff, slewed;

   // Four filter taps in parallel
   assign prod_be = cfg.coef_br * error;
   assign prod_bd = cfg.coef_br * error_d2_ff;
   assign prod_a1 = cfg.coef_a1 * resonant_d1_ff;
   assign prod_a2 = cfg.coef_a2 * resonant_d2_ff;

   // Exact sum, then one floor shift back to the sample format
   assign sum = prc_pkg::SUM_W'(prod_be) - prc_pkg::SUM_W'(prod_bd)
              - prc_pkg::SUM_W'(prod_a1) - prc_pkg::SUM_W'(prod_a2);
   assign ur_raw = $signed(sum[prc_pkg::SUM_W-1:prc_pkg::COEF_SHIFT]);

   assign ur_ext   = prc_pkg::DIFF_W'(ur_raw);
   assign hist_ext = prc_pkg::DIFF_W'(resonant_d1_ff);
   assign diff     = ur_ext - hist_ext;

   // Slew limit against the last value, then clamp (maximum wins)
   always_comb begin
      if (diff < -ONE_W) begin
         slewed = hist_ext - ONE_W;
      end else if (diff >= ONE_W) begin
         slewed = hist_ext + ONE_W;
      end else begin
         slewed = ur_ext;
      end

      if (slewed > prc_pkg::DIFF_W'(cfg.res_max)) begin
         resonant = cfg.res_max;
      end else if (slewed <= prc_pkg::DIFF_W'(cfg.res_min)) begin
         resonant = cfg.res_min;
      end else begin
         resonant = slewed[DW-1:0];
      end
   end

   // Advance the history once per request
   always_ff @(posedge clock) begin
      if (reset) begin
         error_d1_ff    <= '0;
         error_d2_ff    <= '0;
         resonant_d1_ff <= prc_pkg::INIT_RESONANT;
         resonant_d2_ff <= prc_pkg::INIT_RESONANT;
      end else if (step_en) begin
         error_d1_ff    <= error;
         error_d2_ff    <= error_d1_ff;
         resonant_d1_ff <= resonant;
         resonant_d2_ff <= resonant_d1_ff;
      end
   end

endmodule

// ----- hdl/proportional_resonant_controller.sv -----
// A request accepted on req_ passes through the input, resonant and output registers in
// turn before its result shows on rsp_. Throughput: one request per cycle while
// rsp_tready does not stall the output; the resonant recurrence is combinational from
// the history registers through the four parallel multipliers, their sum, the slew
// limit and the clamp.
// Reset (synchronous, active high) empties the pipeline, zeroes the error history,
// loads the resonant history with its initial value and restores register defaults.
module proportional_resonant_controller (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [31:0]                           req_tdata,   // [31:0] error_in
   // result channel
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [63:0]                           rsp_tdata,   // [31:0] drive_out,
                                                              // [63:32] resonant_out
   // register writes
   input  logic                                  csr_wr_en,
   input  logic [prc_pkg::CSR_ADDR_W-1:0]        csr_addr,
   input  logic [31:0]                           csr_wr_data
);

   localparam int DW = prc_pkg::DATA_W;

   logic signed [DW-1:0] coef_a1_ff, coef_a2_ff, coef_br_ff, prop_gain_ff;
   logic signed [DW-1:0] res_max_ff, res_min_ff, out_max_ff, out_min_ff;

   logic                              s1_v_ff, s2_v_ff, out_v_ff;
   logic                              s1_adv, s2_adv, out_adv;
   logic signed [DW-1:0]              s1_error_ff;
   logic signed [DW-1:0]              s2_res_ff;
   logic signed [prc_pkg::UP_W-1:0]   s2_up_ff;
   logic signed [DW-1:0]              drive_ff, res_out_ff;

   prc_pkg::res_cfg_type              res_cfg;
   logic signed [DW-1:0]              resonant_in;
   logic signed [2*DW-1:0]            prod_kp;
   logic signed [prc_pkg::UP_W-1:0]   up_in;
   logic signed [prc_pkg::DRIVE_W-1:0] drive_sum;
   logic signed [DW-1:0]              drive_in;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_a1_ff   <= '0;
         coef_a2_ff   <= '0;
         coef_br_ff   <= '0;
         prop_gain_ff <= '0;
         res_max_ff   <= 32'sh7FFF_FFFF;
         res_min_ff   <= 32'sh8000_0000;
         out_max_ff   <= 32'sh7FFF_FFFF;
         out_min_ff   <= 32'sh8000_0000;
      end else if (csr_wr_en) begin
         case (prc_pkg::csr_index_type'(csr_addr))
            prc_pkg::CSR_COEF_A1:   coef_a1_ff   <= csr_wr_data;
            prc_pkg::CSR_COEF_A2:   coef_a2_ff   <= csr_wr_data;
            prc_pkg::CSR_COEF_BR:   coef_br_ff   <= csr_wr_data;
            prc_pkg::CSR_PROP_GAIN: prop_gain_ff <= csr_wr_data;
            prc_pkg::CSR_RES_MAX:   res_max_ff   <= csr_wr_data;
            prc_pkg::CSR_RES_MIN:   res_min_ff   <= csr_wr_data;
            prc_pkg::CSR_OUT_MAX:   out_max_ff   <= csr_wr_data;
            prc_pkg::CSR_OUT_MIN:   out_min_ff   <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // Stage advance: a stage moves when the next one is empty or moving
   assign out_adv    = !out_v_ff || rsp_tready;
   assign s2_adv     = !s2_v_ff || out_adv;
   assign s1_adv     = !s1_v_ff || s2_adv;
   assign req_tready = s1_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (s1_adv) s1_v_ff  <= req_tvalid;
         if (s2_adv) s2_v_ff  <= s1_v_ff;
         if (out_adv) out_v_ff <= s2_v_ff;
      end
   end

   // Resonant branch; history steps when the request leaves the input stage
   assign res_cfg = '{coef_a1: coef_a1_ff, coef_a2: coef_a2_ff, coef_br: coef_br_ff,
                      res_max: res_max_ff, res_min: res_min_ff};

   prc_resonant u_resonant (
      .clock    (clock),
      .reset    (reset),
      .step_en  (s1_v_ff && s2_adv),
      .error    (s1_error_ff),
      .cfg      (res_cfg),
      .resonant (resonant_in)
   );

   // Proportional term, floor shift from Q.(FRAC+24)
   assign prod_kp = prop_gain_ff * s1_error_ff;
   assign up_in   = $signed(prod_kp[2*DW-1:prc_pkg::KP_SHIFT]);

   // Drive sum and output clamp (maximum wins)
   assign drive_sum = prc_pkg::DRIVE_W'(s2_up_ff) + prc_pkg::DRIVE_W'(s2_res_ff);

   always_comb begin
      if (drive_sum > prc_pkg::DRIVE_W'(out_max_ff)) begin
         drive_in = out_max_ff;
      end else if (drive_sum < prc_pkg::DRIVE_W'(out_min_ff)) begin
         drive_in = out_min_ff;
      end else begin
         drive_in = drive_sum[DW-1:0];
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (s1_adv) s1_error_ff <= $signed(req_tdata);
      if (s2_adv) begin
         s2_res_ff <= resonant_in;
         s2_up_ff  <= up_in;
      end
      if (out_adv) begin
         drive_ff   <= drive_in;
         res_out_ff <= s2_res_ff;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {res_out_ff, drive_ff};

`ifndef NO_ASSERTIONS
   a_accept_fills_s1 : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> s1_v_ff)
      else $error("accepted request missing from input stage");

   a_s1_moves_to_s2 : assert property (@(posedge clock) disable iff (reset)
      (s1_v_ff && s2_adv) |=> s2_v_ff)
      else $error("request lost between input and resonant stage");

   a_s2_holds : assert property (@(posedge clock) disable iff (reset)
      (s2_v_ff && !out_adv) |=> (s2_v_ff && $stable(s2_res_ff) && $stable(s2_up_ff)))
      else $error("stalled resonant stage changed");

   a_reset_empties : assert property (@(posedge clock)
      reset |=> (!s1_v_ff && !s2_v_ff && !rsp_tvalid))
      else $error("pipeline not empty after reset");
`endif

endmodule
